FILE: rtl/pli_pkg.sv
// types and constants shared by the positional list insert/delete unit
// no dependencies
`timescale 1ns / 1ps

package pli_pkg;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DELETE = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam int VALUE_W     = 32;
    localparam int POS_W       = 16;
    localparam int OUT_COUNT_W = 5;
    // wide enough for any index in the supported depth range
    localparam int CTL_IDX_W   = 8;

    typedef struct packed {
        logic                      cmd;
        logic signed [VALUE_W-1:0] value;
        logic signed [POS_W-1:0]   position;
    } t_in_word;

    typedef struct packed {
        logic signed [VALUE_W-1:0] removed_value;
        logic [1:0]                status;
        logic [OUT_COUNT_W-1:0]    count;
    } t_out_word;

    typedef struct packed {
        logic                 ins;
        logic                 del;
        logic [CTL_IDX_W-1:0] idx;
        logic [VALUE_W-1:0]   value;
    } t_cell_ctl;

endpackage

FILE: rtl/pli_cell.sv
// one list element: holds its value, loads the new word, or takes a neighbor on a shift
// depends on pli_pkg
`timescale 1ns / 1ps

module pli_cell #(
    parameter int IDX = 0
) (
    input  logic                       i_clk,
    input  pli_pkg::t_cell_ctl         i_ctl,
    input  logic [pli_pkg::VALUE_W-1:0] i_left,
    input  logic [pli_pkg::VALUE_W-1:0] i_right,
    output logic [pli_pkg::VALUE_W-1:0] o_q
);
    import pli_pkg::*;

    localparam logic [CTL_IDX_W-1:0] MY_IDX = CTL_IDX_W'(IDX);

    logic [VALUE_W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        priority if (i_ctl.ins && (i_ctl.idx == MY_IDX)) begin
            r_q <= i_ctl.value;
        end else if (i_ctl.ins && (i_ctl.idx < MY_IDX)) begin
            r_q <= i_left;
        end else if (i_ctl.del && (i_ctl.idx <= MY_IDX)) begin
            r_q <= i_right;
        end else begin
            r_q <= r_q;
        end
    end

    assign o_q = r_q;

endmodule

FILE: rtl/positional_list_insert_delete_unit.sv
// positional list insert/delete: one command in, one result word out per command
// result registered, valid the cycle after accept; one command per cycle unless stalled
// the cell row shifts up or down as each command is accepted, so no command waits on another
// reset clears the element count and the output valid; element cells are not reset
// depends on pli_pkg and pli_cell
`timescale 1ns / 1ps

module positional_list_insert_delete_unit #(
    parameter int DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  pli_pkg::t_in_word  i_data,
    output logic               o_valid,
    input  logic               i_stall,
    output pli_pkg::t_out_word o_data
);
    import pli_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    logic [CW-1:0]      r_count, n_count;
    logic               r_out_valid, n_out_valid;
    t_out_word          r_out, n_out;

    logic               accept;
    logic               full, empty;
    logic signed [16:0] pos_x, pos_m1, n_x;
    logic [IW-1:0]      ins_idx, del_idx, sel_idx;
    logic [VALUE_W-1:0] removed;
    t_cell_ctl          ctl;

    logic [VALUE_W-1:0] cell_q [DEPTH];

    assign accept  = i_valid && !o_stall;
    assign o_stall = r_out_valid && i_stall;
    assign full    = (r_count == FULL_COUNT);
    assign empty   = (r_count == '0);

    assign pos_x  = 17'(i_data.position);
    assign pos_m1 = pos_x - 17'sd1;
    assign n_x    = signed'(17'(r_count));

    always_comb begin
        priority if (pos_x <= 17'sd1) begin
            ins_idx = '0;
        end else if (pos_x >= n_x) begin
            ins_idx = IW'(r_count);
        end else begin
            ins_idx = IW'(pos_m1);
        end
    end

    always_comb begin
        priority if (pos_x <= 17'sd1) begin
            del_idx = '0;
        end else if (pos_m1 >= n_x - 17'sd1) begin
            del_idx = IW'(r_count - CW'(1));
        end else begin
            del_idx = IW'(pos_m1);
        end
    end

    assign sel_idx = (i_data.cmd == CMD_DELETE) ? del_idx : ins_idx;

    assign ctl.ins   = accept && (i_data.cmd == CMD_INSERT) && !full;
    assign ctl.del   = accept && (i_data.cmd == CMD_DELETE) && !empty;
    assign ctl.idx   = CTL_IDX_W'(sel_idx);
    assign ctl.value = i_data.value;

    // row of cells fed by neighbors; head's left is the input value, tail's right is itself
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [VALUE_W-1:0] left, right;
        if (g == 0) begin : g_head
            assign left = i_data.value;
        end else begin : g_mid_l
            assign left = cell_q[g-1];
        end
        if (g == DEPTH - 1) begin : g_tail
            assign right = cell_q[g];
        end else begin : g_mid_r
            assign right = cell_q[g+1];
        end
        pli_cell #(.IDX(g)) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (ctl),
            .i_left  (left),
            .i_right (right),
            .o_q     (cell_q[g])
        );
    end

    // pick the deleted element out of the row
    always_comb begin
        removed = '0;
        for (int k = 0; k < DEPTH; k++) begin
            removed = removed | (cell_q[k] & {VALUE_W{del_idx == IW'(k)}});
        end
    end

    always_comb begin
        n_count = r_count;
        n_out   = r_out;
        if (accept) begin
            n_out.removed_value = '0;
            n_out.status        = ST_OK;
            if (i_data.cmd == CMD_INSERT) begin
                if (full) begin
                    n_out.status = ST_FULL;
                end else begin
                    n_count = r_count + CW'(1);
                end
            end else begin
                if (empty) begin
                    n_out.status        = ST_EMPTY;
                    n_out.removed_value = {1'b1, {(VALUE_W-1){1'b0}}};
                end else begin
                    n_out.removed_value = removed;
                    n_count             = r_count - CW'(1);
                end
            end
            n_out.count = OUT_COUNT_W'(n_count);
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (accept) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

FILE: rtl/pli_chk.sv
// port-level checks for the positional list unit, bound to the top level
// depends on pli_pkg and positional_list_insert_delete_unit
`timescale 1ns / 1ps

module pli_chk #(
    parameter int DEPTH = 16
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input pli_pkg::t_in_word  i_data,
    input logic               o_valid,
    input logic               i_stall,
    input pli_pkg::t_out_word o_data
);
    import pli_pkg::*;

    // held result word stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("result word changed while stalled");

    // input stall only comes from a waiting result
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no pending result");

    // empty delete reports an empty list and the most negative value
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_data.status == ST_EMPTY) |->
            (o_data.count == '0) && (o_data.removed_value == 32'sh8000_0000))
        else $error("bad empty-delete result");

    // dropped insert only when full
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_data.status == ST_FULL) |->
            (o_data.count == OUT_COUNT_W'(DEPTH)) && (o_data.removed_value == '0))
        else $error("bad full-insert result");

    // an accepted insert shows its result next cycle with a zero removed value
    a_ins_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && (i_data.cmd == CMD_INSERT) |=>
            o_valid && (o_data.removed_value == '0) && (o_data.status != ST_EMPTY))
        else $error("insert result missing or malformed");

endmodule

bind positional_list_insert_delete_unit pli_chk #(.DEPTH(DEPTH)) u_pli_chk (.*);
